>>> rtl/core/ptlf_pkg.sv
// Shared constants, types and codes for the page table replacement block.
`timescale 1ns / 1ps
package ptlf_pkg;

    localparam int NUM_PAGES  = 64;
    localparam int NUM_FRAMES = 16;
    localparam int TIME_BITS  = 32;

    localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int LEN_W   = $clog2(NUM_FRAMES + 1);
    localparam int IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W   = 32;
    localparam int ADDR_W  = 4;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_MEM    = 2'd1,
        ST_DISK   = 2'd2
    } page_status_t;

    typedef enum logic [1:0] {
        REG_POLICY = 2'd0,
        REG_PAGES  = 2'd1,
        REG_FRAMES = 2'd2
    } reg_index_t;

    typedef enum logic {
        POL_LRU  = 1'b0,
        POL_FIFO = 1'b1
    } policy_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_VICT,
        S_LOAD,
        S_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 dirty;
        logic [FRAME_W-1:0]   frame;
        logic [TIME_BITS-1:0] atime;
        logic [TIME_BITS-1:0] ltime;
        logic [CNT_W-1:0]     rcnt;
        logic [CNT_W-1:0]     wcnt;
    } entry_t;

    typedef struct packed {
        logic              policy;
        logic [6:0]        pages_in_use;
        logic [4:0]        frames_in_use;
    } cfg_t;

    typedef struct packed {
        logic              rm_en;
        logic [PAGE_W-1:0] rm_page;
        logic              ins_front;
        logic              ins_back;
        logic [PAGE_W-1:0] ins_page;
    } order_op_t;

endpackage

>>> rtl/core/ptlf_in_if.sv
// Input channel carrying one page reference per beat.
`timescale 1ns / 1ps
interface ptlf_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  page;
    logic        is_write;
    logic [31:0] time_stamp;

    modport source (output valid, page, is_write, time_stamp, input ready);
    modport sink   (input valid, page, is_write, time_stamp, output ready);
endinterface

>>> rtl/core/ptlf_out_if.sv
// Output channel carrying one lookup result per beat.
`timescale 1ns / 1ps
interface ptlf_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] frame;
    logic       hit;
    logic       evicted;
    logic [5:0] victim_page;
    logic       victim_dirty;
    logic       bad_page;

    modport source (output valid, frame, hit, evicted, victim_page, victim_dirty, bad_page,
                    input ready);
    modport sink   (input valid, frame, hit, evicted, victim_page, victim_dirty, bad_page,
                    output ready);
endinterface

>>> rtl/core/ptlf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ptlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/ptlf_cfg.sv
// APB register file for policy, page count and frame count.
`timescale 1ns / 1ps
module ptlf_cfg
    import ptlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);
    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy        <= POL_LRU;
            cfg_reg.pages_in_use  <= 7'd64;
            cfg_reg.frames_in_use <= 5'd16;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_POLICY: cfg_reg.policy        <= pwdata[0];
                REG_PAGES:  cfg_reg.pages_in_use  <= pwdata[6:0];
                REG_FRAMES: cfg_reg.frames_in_use <= pwdata[4:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_POLICY: prdata = {31'd0, cfg_reg.policy};
                REG_PAGES:  prdata = {25'd0, cfg_reg.pages_in_use};
                REG_FRAMES: prdata = {27'd0, cfg_reg.frames_in_use};
                default:    prdata = '0;
            endcase
        end
    end
endmodule

>>> rtl/core/ptlf_order.sv
// Ordered list of resident pages with remove, push-front and append.
`timescale 1ns / 1ps
module ptlf_order
    import ptlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_en,
    input  order_op_t         op,
    output logic [PAGE_W-1:0] head,
    output logic [PAGE_W-1:0] tail,
    output logic [LEN_W-1:0]  len
);
    logic [PAGE_W-1:0] lst_reg  [NUM_FRAMES];
    logic [PAGE_W-1:0] lst_next [NUM_FRAMES];
    logic [PAGE_W-1:0] rem      [NUM_FRAMES];
    logic [LEN_W-1:0]  len_reg, len_next, rlen, tlen;
    logic              found;

    assign head = lst_reg[0];
    assign tail = lst_reg[IDX_W'(len_reg - 1'b1)];
    assign len  = len_reg;

    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            // Once the removed page is passed, every later entry moves up one place.
            found  = found || (op.rm_en && lst_reg[i] == op.rm_page && LEN_W'(i) < len_reg);
            rem[i] = lst_reg[i];
            if (found && i < NUM_FRAMES - 1)
            begin
                rem[i] = lst_reg[(i + 1) % NUM_FRAMES];
            end
        end
        rlen     = len_reg - LEN_W'(found);
        lst_next = rem;
        len_next = rlen;
        tlen     = (rlen >= LEN_W'(NUM_FRAMES)) ? LEN_W'(NUM_FRAMES - 1) : rlen;
        if (op.ins_front)
        begin
            lst_next[0] = op.ins_page;
            for (int i = 1; i < NUM_FRAMES; i++)
            begin
                lst_next[i] = rem[i - 1];
            end
            len_next = tlen + 1'b1;
        end
        else if (op.ins_back && rlen < LEN_W'(NUM_FRAMES))
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                if (LEN_W'(i) == rlen)
                begin
                    lst_next[i] = op.ins_page;
                end
            end
            len_next = rlen + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (op_en)
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_en)
        begin
            lst_reg <= lst_next;
        end
    end
endmodule

>>> rtl/core/page_table_lru_fifo_replacement.sv
// Top level of the demand-paging page table with LRU or FIFO replacement.
`timescale 1ns / 1ps
// Usage:
// The req channel takes one page reference per beat: page number, read or
// write, and a time stamp. The res channel returns exactly one beat per
// reference with the frame, hit, eviction, victim page, victim dirty flag
// and a bad page flag. Configuration (policy, pages in use, frames in use)
// is written over the APB port; the user must write it only while the
// block is idle, as the block does not enforce this. The per-page table
// sits in one RAM with a registered read, and each item walks a read,
// modify, write-back sequence: a bad page goes straight to done, a hit
// passes look and update, a fault with a free frame also load, and a fault
// that evicts also victim (extra read and write of the victim entry). The
// recency and load orders are updated one list operation per cycle. One
// item is in work at a time; the next beat is taken in the cycle after the
// previous result is loaded into the output register.
// Reset clears the control state, the order lengths and one valid bit
// per page, so unwritten pages read as never used; there is no clearing
// pass. When the receiver stalls, the finished result holds in the output
// register and the sequencer waits before it overwrites it.
module page_table_lru_fifo_replacement
    import ptlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    ptlf_in_if.sink           req,
    ptlf_out_if.source        res
);
    cfg_t cfg;

    state_t state_reg, state_next;

    logic [PAGE_W-1:0]    pg_reg, pg_next;
    logic                 wr_reg, wr_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    entry_t               ent_reg, ent_next;
    logic [FRAME_W-1:0]   fr_reg, fr_next;
    logic                 hit_reg, hit_next;
    logic                 ev_reg, ev_next;
    logic [PAGE_W-1:0]    vpg_reg, vpg_next;
    logic                 vd_reg, vd_next;
    logic                 bad_reg, bad_next;
    logic [LEN_W-1:0]     fg_reg, fg_next;
    logic [NUM_PAGES-1:0] valid_reg;

    logic                 out_valid_reg;
    logic [3:0]           o_frame_reg;
    logic                 o_hit_reg, o_ev_reg, o_vd_reg, o_bad_reg;
    logic [5:0]           o_vpg_reg;
    logic                 out_load;

    // Table RAM ports.
    logic                 ram_we;
    logic [PAGE_W-1:0]    ram_waddr, ram_raddr;
    entry_t               ram_wdata, ram_rdata, rd_ent;
    logic                 rd_valid;
    // Address of the entry now on the RAM read port.
    logic [PAGE_W-1:0]    ram_waddr_rd_q;

    // Order lists.
    logic                 rec_en, ld_en;
    order_op_t            rec_op, ld_op;
    logic [PAGE_W-1:0]    rec_head, rec_tail, ld_head, ld_tail;
    logic [LEN_W-1:0]     rec_len, ld_len;

    logic [6:0]           lim_pages;
    logic [LEN_W-1:0]     lim_frames;

    ptlf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptlf_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_PAGES)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ptlf_order u_recency (
        .clk   (clk),
        .rst_n (rst_n),
        .op_en (rec_en),
        .op    (rec_op),
        .head  (rec_head),
        .tail  (rec_tail),
        .len   (rec_len)
    );

    ptlf_order u_load (
        .clk   (clk),
        .rst_n (rst_n),
        .op_en (ld_en),
        .op    (ld_op),
        .head  (ld_head),
        .tail  (ld_tail),
        .len   (ld_len)
    );

    // Effective limits: page count capped at the table size, frame count
    // held within one to the number of frames.
    always_comb
    begin
        lim_pages = (cfg.pages_in_use > 7'(NUM_PAGES)) ? 7'(NUM_PAGES) : cfg.pages_in_use;
        if (cfg.frames_in_use > 5'(NUM_FRAMES))
        begin
            lim_frames = LEN_W'(NUM_FRAMES);
        end
        else if (cfg.frames_in_use == 5'd0)
        begin
            lim_frames = LEN_W'(1);
        end
        else
        begin
            lim_frames = LEN_W'(cfg.frames_in_use);
        end
    end

    // A page that was never written reads as unused, clean and with zero
    // counts; its frame and times are never looked at.
    always_comb
    begin
        rd_valid = valid_reg[ram_waddr_rd_q];
        rd_ent   = ram_rdata;
        if (!rd_valid)
        begin
            rd_ent.status = ST_UNUSED;
            rd_ent.dirty  = 1'b0;
            rd_ent.rcnt   = '0;
            rd_ent.wcnt   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        ram_waddr_rd_q <= ram_raddr;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        pg_next    = pg_reg;
        wr_next    = wr_reg;
        t_next     = t_reg;
        ent_next   = ent_reg;
        fr_next    = fr_reg;
        hit_next   = hit_reg;
        ev_next    = ev_reg;
        vpg_next   = vpg_reg;
        vd_next    = vd_reg;
        bad_next   = bad_reg;
        fg_next    = fg_reg;
        ram_we     = 1'b0;
        ram_waddr  = pg_reg;
        ram_wdata  = ent_reg;
        ram_raddr  = PAGE_W'(req.page);
        rec_en     = 1'b0;
        ld_en      = 1'b0;
        rec_op     = '0;
        ld_op      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pg_next  = PAGE_W'(req.page);
                    wr_next  = req.is_write;
                    t_next   = TIME_BITS'(req.time_stamp);
                    fr_next  = '0;
                    hit_next = 1'b0;
                    ev_next  = 1'b0;
                    vpg_next = '0;
                    vd_next  = 1'b0;
                    bad_next = ({1'b0, req.page} >= lim_pages) ||
                               ({1'b0, req.page} >= 7'(NUM_PAGES));
                    state_next = bad_next ? S_DONE : S_LOOK;
                end
            end
            S_LOOK:
            begin
                ent_next = rd_ent;
                if (rd_ent.status == ST_MEM)
                begin
                    hit_next   = 1'b1;
                    fr_next    = rd_ent.frame;
                    state_next = S_UPD;
                end
                else if (fg_reg < lim_frames)
                begin
                    fr_next    = FRAME_W'(fg_reg);
                    fg_next    = fg_reg + 1'b1;
                    state_next = S_LOAD;
                end
                else if (cfg.policy == POL_LRU && rec_len != '0)
                begin
                    vpg_next   = rec_tail;
                    ram_raddr  = rec_tail;
                    state_next = S_VICT;
                end
                else if (cfg.policy == POL_FIFO && ld_len != '0)
                begin
                    vpg_next   = ld_head;
                    ram_raddr  = ld_head;
                    state_next = S_VICT;
                end
                else
                begin
                    fr_next    = '0;
                    state_next = S_LOAD;
                end
            end
            S_VICT:
            begin
                // Victim goes to disk; its frame is handed to the new page.
                ev_next          = 1'b1;
                vd_next          = rd_ent.dirty;
                fr_next          = rd_ent.frame;
                ram_we           = 1'b1;
                ram_waddr        = vpg_reg;
                ram_wdata        = rd_ent;
                ram_wdata.status = ST_DISK;
                ram_wdata.dirty  = 1'b0;
                ram_wdata.frame  = '0;
                ram_wdata.atime  = '0;
                ram_wdata.ltime  = '0;
                rec_en           = 1'b1;
                ld_en            = 1'b1;
                rec_op.rm_en     = 1'b1;
                rec_op.rm_page   = vpg_reg;
                ld_op.rm_en      = 1'b1;
                ld_op.rm_page    = vpg_reg;
                state_next       = S_LOAD;
            end
            S_LOAD:
            begin
                ent_next.status = ST_MEM;
                ent_next.dirty  = 1'b0;
                ent_next.frame  = fr_reg;
                ent_next.ltime  = t_reg;
                ld_en           = 1'b1;
                ld_op.rm_en     = 1'b1;
                ld_op.rm_page   = pg_reg;
                ld_op.ins_back  = 1'b1;
                ld_op.ins_page  = pg_reg;
                state_next      = S_UPD;
            end
            S_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = pg_reg;
                ram_wdata = ent_reg;
                if (wr_reg)
                begin
                    ram_wdata.dirty = 1'b1;
                    if (ent_reg.wcnt != '1)
                    begin
                        ram_wdata.wcnt = ent_reg.wcnt + 1'b1;
                    end
                end
                else if (ent_reg.rcnt != '1)
                begin
                    ram_wdata.rcnt = ent_reg.rcnt + 1'b1;
                end
                ram_wdata.atime  = t_reg;
                fr_next          = ent_reg.frame;
                rec_en           = 1'b1;
                rec_op.rm_en     = 1'b1;
                rec_op.rm_page   = pg_reg;
                rec_op.ins_front = 1'b1;
                rec_op.ins_page  = pg_reg;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fg_reg    <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fg_reg    <= fg_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pg_reg  <= pg_next;
        wr_reg  <= wr_next;
        t_reg   <= t_next;
        ent_reg <= ent_next;
        fr_reg  <= fr_next;
        hit_reg <= hit_next;
        ev_reg  <= ev_next;
        vpg_reg <= vpg_next;
        vd_reg  <= vd_next;
        bad_reg <= bad_next;
    end

    // Output register: holds a result until the receiver takes the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_frame_reg <= 4'(fr_reg);
            o_hit_reg   <= hit_reg;
            o_ev_reg    <= ev_reg;
            o_vpg_reg   <= 6'(vpg_reg);
            o_vd_reg    <= vd_reg;
            o_bad_reg   <= bad_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.frame        = o_frame_reg;
    assign res.hit          = o_hit_reg;
    assign res.evicted      = o_ev_reg;
    assign res.victim_page  = o_vpg_reg;
    assign res.victim_dirty = o_vd_reg;
    assign res.bad_page     = o_bad_reg;

    // Frames handed out never exceed the frame count.
    assert property (@(posedge clk) disable iff (!rst_n) fg_reg <= LEN_W'(NUM_FRAMES))
        else $error("frames given above frame count");

    // Both orders hold the same number of pages between items.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_IDLE) |-> (rec_len == ld_len))
        else $error("recency and load order lengths differ");

    // An accepted reference always starts a sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted beat did not start work");

    // An eviction always reports a hit of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (res.valid && res.evicted) |-> !res.hit)
        else $error("eviction reported on a hit");
endmodule

>>> verif/page_table_lru_fifo_replacement_checker.sv
// Checker that predicts page table results from observed references and compares them.
`timescale 1ns / 1ps
module page_table_lru_fifo_replacement_checker
    import ptlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic       pready,
    ptlf_in_if         req,
    ptlf_out_if        res,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [3:0] frame;
        logic       hit;
        logic       evicted;
        logic [5:0] victim_page;
        logic       victim_dirty;
        logic       bad_page;
    } lookup_t;

    logic       cur_policy;
    logic [6:0] cur_pages;
    logic [4:0] cur_frames;

    page_status_t status_tab [NUM_PAGES];
    logic         dirty_tab  [NUM_PAGES];
    logic [3:0]   frame_tab  [NUM_PAGES];
    int           frames_handed;
    logic [5:0]   recent_q [$];
    logic [5:0]   loaded_q [$];
    lookup_t      lookup_q [$];

    // Drops one page from a residency list wherever it sits.
    function automatic void drop_page(ref logic [5:0] lst [$], input logic [5:0] pg);
        for (int i = lst.size() - 1; i >= 0; i--)
            if (lst[i] == pg)
                lst.delete(i);
    endfunction

    function automatic lookup_t resolve_ref(logic [5:0] pg, logic wr);
        lookup_t r;
        int      page_lim;
        int      frame_lim;
        logic [5:0] vpg;
        r = '0;
        page_lim  = (cur_pages > NUM_PAGES) ? NUM_PAGES : cur_pages;
        frame_lim = (cur_frames > NUM_FRAMES) ? NUM_FRAMES : cur_frames;
        if (frame_lim < 1)
            frame_lim = 1;
        if (pg >= page_lim)
        begin
            r.bad_page = 1'b1;
            return r;
        end
        if (status_tab[pg] == ST_MEM)
            r.hit = 1'b1;
        else
        begin
            if (frames_handed < frame_lim)
            begin
                frame_tab[pg] = frames_handed[3:0];
                frames_handed++;
            end
            else
            begin
                vpg = (cur_policy == POL_LRU) ? recent_q[$] : loaded_q[0];
                r.evicted      = 1'b1;
                r.victim_page  = vpg;
                r.victim_dirty = dirty_tab[vpg];
                frame_tab[pg]  = frame_tab[vpg];
                status_tab[vpg] = ST_DISK;
                dirty_tab[vpg]  = 1'b0;
                drop_page(recent_q, vpg);
                drop_page(loaded_q, vpg);
            end
            status_tab[pg] = ST_MEM;
            dirty_tab[pg]  = 1'b0;
            drop_page(loaded_q, pg);
            loaded_q.push_back(pg);
        end
        if (wr)
            dirty_tab[pg] = 1'b1;
        drop_page(recent_q, pg);
        recent_q.push_front(pg);
        r.frame = frame_tab[pg];
        return r;
    endfunction

    always_comb pending = lookup_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t got;
        lookup_t want;
        if (!rst_n)
        begin
            cur_policy    <= POL_LRU;
            cur_pages     <= 7'd64;
            cur_frames    <= 5'd16;
            frames_handed = 0;
            recent_q.delete();
            loaded_q.delete();
            lookup_q.delete();
            fail_count    <= 0;
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                status_tab[i] = ST_UNUSED;
                dirty_tab[i]  = 1'b0;
                frame_tab[i]  = '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_POLICY: cur_policy <= pwdata[0];
                    REG_PAGES:  cur_pages  <= pwdata[6:0];
                    REG_FRAMES: cur_frames <= pwdata[4:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                lookup_q.push_back(resolve_ref(req.page, req.is_write));
            if (res.valid && res.ready)
            begin
                got = {res.frame, res.hit, res.evicted, res.victim_page,
                       res.victim_dirty, res.bad_page};
                if (lookup_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected frame %0d hit %b ev %b vp %0d vd %b bad %b, got frame %0d hit %b ev %b vp %0d vd %b bad %b",
                                     want.frame, want.hit, want.evicted, want.victim_page,
                                     want.victim_dirty, want.bad_page, got.frame, got.hit,
                                     got.evicted, got.victim_page, got.victim_dirty,
                                     got.bad_page);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/page_table_lru_fifo_replacement_test.sv
// Top of the page table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module page_table_lru_fifo_replacement_test;
    import ptlf_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    logic [6:0]        page_span;

    ptlf_in_if  req ();
    ptlf_out_if res ();

    page_table_lru_fifo_replacement dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req.sink), .res(res.source)
    );

    page_table_lru_fifo_replacement_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .req(req), .res(res),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // The receiver draws a fresh stall for every beat; a quiet stretch in
    // the middle of the run keeps ready high so back-to-back beats occur.
    logic quiet_sink;
    always @(posedge clk or negedge rst_n)
    begin
        int wait_left;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            wait_left = 0;
        end
        else if (quiet_sink)
            res.ready <= 1'b1;
        else if (res.ready && res.valid)
        begin
            wait_left = $urandom_range(0, 7);
            res.ready <= (wait_left == 0);
        end
        else if (!res.ready)
        begin
            if (wait_left > 0)
                wait_left--;
            res.ready <= (wait_left == 0);
        end
    end

    // The watchdog counts cycles without any beat on either channel. A
    // slow item with a full stall stays far below the limit.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Register writes use a setup phase followed by an access phase.
    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends one reference after a random gap, then holds it until taken.
    // Valid stays high after the beat; the next reference with a gap, or
    // the drain, takes it down, so a back-to-back beat follows directly.
    task automatic send_ref(logic [5:0] pg, logic wr, logic [31:0] stamp, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.page       <= pg;
        req.is_write   <= wr;
        req.time_stamp <= stamp;
        do @(posedge clk); while (!req.ready);
    endtask

    // Lets every outstanding result drain, plus a margin for the pipeline.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int count, int span);
        logic [5:0] pg;
        for (int i = 0; i < count; i++)
        begin
            // Mostly a working set near the frame count, so hits and
            // evictions both occur; now and then any page, even bad ones.
            if ($urandom_range(0, 9) == 0)
                pg = 6'($urandom_range(0, 63));
            else
                pg = 6'($urandom_range(0, span - 1));
            send_ref(pg, 1'($urandom_range(0, 1)), $urandom, ($urandom_range(0, 5) == 0));
        end
    endtask

    initial
    begin
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req.valid   = 1'b0;
        req.page    = '0;
        req.is_write = 1'b0;
        req.time_stamp = '0;
        quiet_sink  = 1'b0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: fill frames, hit, evict a dirty
        // page, extreme page numbers and time stamps.
        send_ref(6'd0, 1'b1, 32'h0000_0000);
        send_ref(6'd63, 1'b0, 32'hFFFF_FFFF);
        send_ref(6'd0, 1'b0, 32'h5555_5555);
        for (int p = 1; p < 17; p++)
            send_ref(6'(p), p[0], 32'hAAAA_AAAA);
        drain();

        // A lowered page count makes high pages bad while they may still be
        // resident victims; a single frame forces an eviction on every miss.
        write_reg(REG_PAGES, 32'd8);
        write_reg(REG_FRAMES, 32'd1);
        write_reg(REG_POLICY, 32'd1);
        send_ref(6'd63, 1'b0, 32'd1);
        send_ref(6'd8, 1'b1, 32'd2);
        send_ref(6'd7, 1'b1, 32'd3);
        send_ref(6'd7, 1'b0, 32'd4);
        send_ref(6'd3, 1'b0, 32'd5);
        drain();

        // Zero pages makes every reference bad; out-of-range frame counts
        // clamp to the legal span.
        write_reg(REG_PAGES, 32'd0);
        write_reg(REG_FRAMES, 32'd0);
        send_ref(6'd0, 1'b1, 32'd6);
        drain();
        write_reg(REG_PAGES, 32'd127);
        write_reg(REG_FRAMES, 32'd31);
        send_ref(6'd40, 1'b1, 32'd7);
        send_ref(6'd41, 1'b0, 32'd8);

        // Random phases across policies and sizes, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_reg(REG_POLICY, 32'(ph[0]));
            case (ph)
                0: page_span = 7'd64;
                1: page_span = 7'd1;
                2: page_span = 7'd20;
                default: page_span = 7'($urandom_range(2, 64));
            endcase
            write_reg(REG_PAGES, 32'(page_span));
            write_reg(REG_FRAMES, (ph == 3) ? 32'd16 : (ph == 4) ? 32'd1
                                  : $urandom_range(1, 16));
            quiet_sink <= (ph == 5);
            random_phase(135, (page_span > 24) ? 24 : page_span);
        end

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> page_table_lru_fifo_replacement.f
rtl/core/ptlf_pkg.sv
rtl/core/ptlf_in_if.sv
rtl/core/ptlf_out_if.sv
rtl/core/ptlf_ram.sv
rtl/core/ptlf_cfg.sv
rtl/core/ptlf_order.sv
rtl/core/page_table_lru_fifo_replacement.sv
verif/page_table_lru_fifo_replacement_checker.sv
verif/page_table_lru_fifo_replacement_test.sv
